// ===== sv/xsbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsbd_pkg: shared types and constants for the bounded draw core
// Command codes, field widths, generator seeding constants and the control
// struct that steers the xorshift generator.
// ----------------------------------------------------------------------------
package xsbd_pkg;

    // field and word widths
    localparam int WORD_W  = 32;
    localparam int VAL_W   = 30;
    localparam int BOUND_W = 31;
    localparam int CMD_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_RAW     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOUNDED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd2;

    // seeding constants
    localparam logic [WORD_W-1:0]  INIT_X      = 32'd123456789;
    localparam logic [BOUND_W-1:0] BOUND_LIMIT = 31'h4000_0000;
    localparam logic [1:0]         SEED_STEPS  = 2'd3;

    // generator control
    typedef struct packed {
        logic load;   // load x from INIT_X, w from the seed, clear y and z
        logic step;   // advance the generator once
    } rng_ctl_t;

endpackage

// ===== sv/xsbd_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsbd_rng: xorshift128 generator state
// Holds the four state words, loads them on reseed and advances them by one
// step per cycle on request. Exposes the next w word for the caller.
// ----------------------------------------------------------------------------
module xsbd_rng
    import xsbd_pkg::*;
(
    input  logic              aclk,
    input  rng_ctl_t          ctl,
    input  logic [WORD_W-1:0] seed,
    output logic [WORD_W-1:0] adv_w
);

    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] z_reg;
    logic [WORD_W-1:0] w_reg;
    logic [WORD_W-1:0] t;

    // one xorshift step
    always_comb begin
        t     = x_reg ^ (x_reg << 11);
        adv_w = w_reg ^ (w_reg >> 19) ^ t ^ (t >> 8);
    end

    // state words
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= INIT_X;
            y_reg <= '0;
            z_reg <= '0;
            w_reg <= seed;
        end else if (ctl.step) begin
            x_reg <= y_reg;
            y_reg <= z_reg;
            z_reg <= w_reg;
            w_reg <= adv_w;
        end
    end

endmodule

// ===== sv/xsbd_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsbd_mod: bit-serial modulo unit
// Restoring remainder, one dividend bit per cycle, most significant first.
// After start it works through all VAL_W bits, then pulses done for one cycle.
// ----------------------------------------------------------------------------
module xsbd_mod
    import xsbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VAL_W-1:0]   dividend,
    input  logic [BOUND_W-1:0] divisor,
    output logic               done,
    output logic [VAL_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [VAL_W-1:0]   dvd_reg;
    logic [BOUND_W-1:0] dvs_reg;
    logic [BOUND_W-1:0] rem_reg;
    logic [BOUND_W-1:0] rem_next;
    logic [BOUND_W-1:0] trial;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // shift in next bit, subtract divisor when it fits
    always_comb begin
        trial = {rem_reg[BOUND_W-2:0], dvd_reg[VAL_W-1]};
        if (trial >= dvs_reg) begin
            rem_next = trial - dvs_reg;
        end else begin
            rem_next = trial;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VAL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[VAL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[VAL_W-1:0];

    // done is a single-cycle pulse
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg)
        else $error("modulo done held longer than one cycle");

    // remainder stays below the divisor when done
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> rem_reg < dvs_reg)
        else $error("modulo remainder not reduced");

    // no restart while stepping
    assert property (@(posedge aclk) disable iff (!aresetn) busy_reg |-> !start)
        else $error("modulo restarted while busy");

endmodule

// ===== sv/xorshift128_bounded_draw_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift128_bounded_draw_core: xorshift128 generator with bounded draws
// Raw draws, rejection-sampled bounded draws and reseeding on command.
//
//   channel  direction  ports                     contents
//   s_       in         s_tdata, s_tuser          range_bound, command
//   m_       out        m_tdata                   value
//   cfg      in/out     psel..prdata (APB)        seed at byte address 0
//
// Raw draw, small bound, unused command: accept, ST_OUT, output register.
// Bounded draw: paced by the bit-serial modulo unit; each rejected draw
// restarts it on a new draw. Reseed: ST_LOAD, ST_SEED steps, then ST_OUT.
// After reset the generator seeds from zero via ST_LOAD/ST_SEED, s_tready low.
// A waiting result does not block the next request; a finished result
// stalls in place while the output register is still full.
// ----------------------------------------------------------------------------
module xorshift128_bounded_draw_core
    import xsbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [30:0] range_bound, [31] zero
    input  logic [1:0]  s_tuser,    // [1:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [29:0] value, [31:30] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SEED = 3'd1;
    localparam logic [2:0] ST_IDLE = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               reply_reg, reply_next;
    logic [BOUND_W-1:0] n_reg, n_next;
    logic [VAL_W-1:0]   k_reg, k_next;
    logic [VAL_W-1:0]   res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]   m_data_reg, m_data_next;
    logic [WORD_W-1:0]  seed_reg;

    logic               s_fire;
    logic               out_free;
    logic [CMD_W-1:0]   cmd;
    logic [BOUND_W-1:0] bound_in;
    logic [BOUND_W-1:0] n_sat;
    logic [BOUND_W-1:0] top_sum;
    logic               draw_ok;

    rng_ctl_t           rng_ctl;
    logic [WORD_W-1:0]  adv_w;
    logic               div_start;
    logic [BOUND_W-1:0] div_divisor;
    logic               div_done;
    logic [VAL_W-1:0]   div_rem;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            seed_reg <= pwdata;
        end
    end

    xsbd_rng u_rng (
        .aclk  (aclk),
        .ctl   (rng_ctl),
        .seed  (seed_reg),
        .adv_w (adv_w)
    );

    xsbd_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (adv_w[VAL_W-1:0]),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // request decode
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cmd      = s_tuser;
    assign bound_in = s_tdata[BOUND_W-1:0];
    assign n_sat    = (bound_in > BOUND_LIMIT) ? BOUND_LIMIT : bound_in;

    // rejection test: k - (k mod n) + n must not pass the limit
    assign top_sum     = {1'b0, k_reg} - {1'b0, div_rem} + n_reg;
    assign draw_ok     = (top_sum <= BOUND_LIMIT);
    assign div_divisor = (state_reg == ST_IDLE) ? n_sat : n_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        reply_next    = reply_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        rng_ctl       = '0;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                rng_ctl.load = 1'b1;
                cnt_next     = SEED_STEPS;
                state_next   = ST_SEED;
            end
            ST_SEED: begin
                rng_ctl.step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == 2'd1) begin
                    res_next   = '0;
                    state_next = reply_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (cmd)
                        CMD_RAW: begin
                            rng_ctl.step = 1'b1;
                            res_next     = adv_w[VAL_W-1:0];
                            state_next   = ST_OUT;
                        end
                        CMD_BOUNDED: begin
                            if (bound_in < BOUND_W'(2)) begin
                                res_next   = '0;
                                state_next = ST_OUT;
                            end else begin
                                rng_ctl.step = 1'b1;
                                div_start    = 1'b1;
                                n_next       = n_sat;
                                k_next       = adv_w[VAL_W-1:0];
                                state_next   = ST_DIV;
                            end
                        end
                        CMD_RESEED: begin
                            reply_next = 1'b1;
                            state_next = ST_LOAD;
                        end
                        default: begin
                            res_next   = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (draw_ok) begin
                        res_next   = div_rem;
                        state_next = ST_OUT;
                    end else begin
                        rng_ctl.step = 1'b1;
                        div_start    = 1'b1;
                        k_next       = adv_w[VAL_W-1:0];
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    reply_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            reply_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            reply_reg    <= reply_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // a taken request drops s_tready until the core returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn) s_fire |=> !s_tready)
        else $error("request accepted while previous still in progress");

    // modulo results only show up while a bounded draw is running
    assert property (@(posedge aclk) disable iff (!aresetn) div_done |-> state_reg == ST_DIV)
        else $error("modulo finished outside a bounded draw");

    // a finished result with room moves to the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> m_tvalid_reg)
        else $error("result not delivered to output register");

    // a bounded draw keeps its bound inside the valid range
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> (n_reg >= BOUND_W'(2) && n_reg <= BOUND_LIMIT))
        else $error("bound out of range during bounded draw");

endmodule
